@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the allocator unit and the divider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define LFLA_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define LFLA_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/lfla_pkg.sv @@
`default_nettype none

package lfla_pkg;

    localparam int ROW_W  = 64;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 4;
    localparam int ADDR_W = 4;

    // Register select is the top address bit (registers sit 8 bytes apart).
    localparam logic REG_ROW_CAP     = 1'b0;
    localparam logic REG_ROWS_IN_USE = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ROUTE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_NEXT,
        S_PDIV,
        S_RAISE,
        S_NDIV1,
        S_NDIV2,
        S_SPREAD,
        S_MIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             go;
        logic [ROW_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [ROW_W-1:0] quot;
        logic [CNT_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ rtl/lowest_first_level_allocator_unit.sv @@
`default_nettype none
`include "assert_macros.svh"
// A load gives no result and leaves busy low for the next item.
// A route walks the rows in passes through the row memory and uses the divider:
// it raises the lowest rows tier by tier and then splits the rest, a negative
// amount is divided twice before its spread, and a route over zero rows stays idle.
// Its n beats leave on consecutive cycles at the end; the receiver cannot stall.
// Synchronous active-low reset: row_cap all ones, rows_in_use zero, rows undefined.

module lowest_first_level_allocator_unit import lfla_pkg::*; #(
    parameter int MAX_ROWS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_op,
    input  wire logic [IDX_W-1:0]        i_row_index,
    input  wire logic [ROW_W-1:0]        i_row_value,
    input  wire logic signed [ROW_W-1:0] i_amount,
    output logic                         o_strobe,
    output logic [IDX_W-1:0]             o_out_index,
    output logic [ROW_W-1:0]             o_out_value,
    output logic [ROW_W-1:0]             o_new_minimum,
    output logic                         o_last,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [ROW_W-1:0]        pwdata,
    output logic [ROW_W-1:0]             prdata,
    output logic                         pready
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;
    localparam int IW = $clog2(MAX_ROWS + 2);

    // Configuration registers. They may only be changed while the block is idle; the block itself does not enforce it.
    logic [ROW_W-1:0] r_cap;
    logic [CNT_W-1:0] r_rows;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= '1;
            r_rows <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[ADDR_W-1])
                REG_ROW_CAP:     r_cap  <= pwdata;
                REG_ROWS_IN_USE: r_rows <= pwdata[CNT_W-1:0];
                default:         r_cap  <= r_cap;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1])
            REG_ROWS_IN_USE: prdata = ROW_W'(r_rows);
            default:         prdata = r_cap;
        endcase
    end

    // Sequencer state. Every pass walks rows 0..n-1 through the row memory:
    // the read is issued, the data comes back in the next cycle, and any
    // modified value is written back in that same cycle. Reads and writes in
    // the same cycle always touch different rows, so no forwarding is needed.
    t_state r_state, n_state;

    logic [CNT_W-1:0] r_n,      n_n;
    logic [CNT_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_dt_ptr, n_dt_ptr;
    logic             r_dt_vld, n_dt_vld;
    logic             r_div_go, n_div_go;
    logic [IW-1:0]    r_iter,   n_iter;

    logic [ROW_W-1:0] r_bud,     n_bud;
    logic [ROW_W-1:0] r_cur,     n_cur;
    logic [ROW_W-1:0] r_next,    n_next;
    logic [ROW_W-1:0] r_gap,     n_gap;
    logic [ROW_W-1:0] r_red,     n_red;
    logic [ROW_W-1:0] r_share,   n_share;
    logic [CNT_W-1:0] r_rem,     n_rem;
    logic [CNT_W-1:0] r_pos,     n_pos;
    logic             r_neg,     n_neg;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic [ROW_W-1:0] r_acc_min, n_acc_min;
    logic [CNT_W-1:0] r_acc_cnt, n_acc_cnt;
    logic [ROW_W-1:0] r_acc_nxt, n_acc_nxt;

    logic             r_o_strobe, n_o_strobe;
    logic [IDX_W-1:0] r_o_index,  n_o_index;
    logic [ROW_W-1:0] r_o_value,  n_o_value;
    logic [ROW_W-1:0] r_o_min,    n_o_min;
    logic             r_o_last,   n_o_last;

    // Row memory ports.
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] rd_data;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // Per-row helpers shared by the next-state and update logic.
    logic [CNT_W-1:0] n_act;
    logic [XW-1:0]    load_ext;
    logic             pass_st, issue, row_end, row_first;
    logic [ROW_W-1:0] clamp_v, mv, min_new;
    logic [CNT_W-1:0] cnt_new, cnt_hit_new;
    logic             hit;
    logic [ROW_W-1:0] nxt_base, nxt_new, del, spread_v, mag;
    logic             gap_big, more_tiers;
    logic [IW-1:0]    iter_inc;

    always_comb begin
        n_act    = (32'(r_rows) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : r_rows;
        load_ext = XW'(i_row_index);

        pass_st = (r_state == S_CLAMP) || (r_state == S_NEXT) || (r_state == S_RAISE)
               || (r_state == S_SPREAD) || (r_state == S_MIN) || (r_state == S_OUT);
        issue     = pass_st && (r_rd_ptr < r_n);
        row_end   = r_dt_vld && (r_dt_ptr == r_n - CNT_W'(1));
        row_first = (r_dt_ptr == '0);

        // Running minimum and how many rows hold it.
        clamp_v = (rd_data > r_cap) ? r_cap : rd_data;
        mv      = (r_state == S_CLAMP) ? clamp_v : rd_data;
        if (row_first || (mv < r_acc_min)) begin
            min_new = mv;
            cnt_new = CNT_W'(1);
        end else if (mv == r_acc_min) begin
            min_new = r_acc_min;
            cnt_new = r_acc_cnt + CNT_W'(1);
        end else begin
            min_new = r_acc_min;
            cnt_new = r_acc_cnt;
        end

        // Count of rows at the current tier and the next tier above it.
        hit         = (rd_data == r_cur);
        cnt_hit_new = (row_first ? '0 : r_acc_cnt) + CNT_W'(hit);
        nxt_base    = row_first ? r_cap : r_acc_nxt;
        nxt_new     = ((rd_data > r_cur) && (rd_data < nxt_base)) ? rd_data : nxt_base;

        // The first rem rows at the minimum take one unit more than the share.
        del      = r_share + ROW_W'(r_pos < r_rem);
        spread_v = r_neg ? (rd_data - del) : (rd_data + del);

        mag        = '0 - r_bud;
        gap_big    = (r_gap > div_rsp.quot);
        iter_inc   = r_iter + IW'(1);
        more_tiers = (32'(iter_inc) <= MAX_ROWS) && (r_bud != '0) && (r_next < r_cap);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && (i_op == OP_ROUTE) && (n_act != '0)) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (row_end) begin
                    priority if (r_bud[ROW_W-1]) begin
                        n_state = S_NDIV1;
                    end else if ((r_bud == '0) || (min_new >= r_cap)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                if (row_end) begin
                    n_state = S_PDIV;
                end
            end
            S_PDIV: begin
                if (div_rsp.done) begin
                    n_state = gap_big ? S_SPREAD : S_RAISE;
                end
            end
            S_RAISE: begin
                if (row_end) begin
                    n_state = more_tiers ? S_NEXT : S_OUT;
                end
            end
            S_NDIV1: begin
                if (div_rsp.done) begin
                    n_state = S_NDIV2;
                end
            end
            S_NDIV2: begin
                if (div_rsp.done) begin
                    n_state = S_SPREAD;
                end
            end
            S_SPREAD: begin
                if (row_end) begin
                    n_state = S_MIN;
                end
            end
            S_MIN: begin
                if (row_end) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (row_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory control and result registers.
    always_comb begin
        busy       = (r_state != S_IDLE);
        ram_we     = 1'b0;
        ram_waddr  = AW'(r_dt_ptr);
        ram_wdata  = rd_data;

        n_n        = r_n;
        n_rd_ptr   = issue ? (r_rd_ptr + CNT_W'(1)) : r_rd_ptr;
        n_dt_ptr   = r_rd_ptr;
        n_dt_vld   = issue;
        n_div_go   = 1'b0;
        n_iter     = r_iter;
        n_bud      = r_bud;
        n_cur      = r_cur;
        n_next     = r_next;
        n_gap      = r_gap;
        n_red      = r_red;
        n_share    = r_share;
        n_rem      = r_rem;
        n_pos      = r_pos;
        n_neg      = r_neg;
        n_cnt      = r_cnt;
        n_acc_min  = r_acc_min;
        n_acc_cnt  = r_acc_cnt;
        n_acc_nxt  = r_acc_nxt;
        n_o_strobe = 1'b0;
        n_o_index  = r_o_index;
        n_o_value  = r_o_value;
        n_o_min    = r_o_min;
        n_o_last   = r_o_last;

        if (row_end) begin
            n_rd_ptr = '0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_op == OP_LOAD) begin
                        if (32'(i_row_index) < MAX_ROWS) begin
                            ram_we    = 1'b1;
                            ram_waddr = load_ext[AW-1:0];
                            ram_wdata = i_row_value;
                        end
                    end else begin
                        n_n      = n_act;
                        n_bud    = i_amount;
                        n_rd_ptr = '0;
                        n_iter   = '0;
                        if (n_act == '0) begin
                            // No rows in use: a single all-zero beat closes the route.
                            n_o_strobe = 1'b1;
                            n_o_index  = '0;
                            n_o_value  = '0;
                            n_o_min    = '0;
                            n_o_last   = 1'b1;
                        end
                    end
                end
            end
            S_CLAMP: begin
                if (r_dt_vld) begin
                    ram_we    = 1'b1;
                    ram_wdata = clamp_v;
                    n_acc_min = min_new;
                    n_acc_cnt = cnt_new;
                end
                if (row_end) begin
                    n_cur    = min_new;
                    n_cnt    = cnt_new;
                    n_div_go = r_bud[ROW_W-1];
                end
            end
            S_NEXT: begin
                if (r_dt_vld) begin
                    n_acc_cnt = cnt_hit_new;
                    n_acc_nxt = nxt_new;
                end
                if (row_end) begin
                    n_cnt    = cnt_hit_new;
                    n_next   = nxt_new;
                    n_gap    = nxt_new - r_cur;
                    n_div_go = 1'b1;
                end
            end
            S_PDIV: begin
                if (div_rsp.done) begin
                    if (gap_big) begin
                        // The budget cannot lift the tier: share it out and stop.
                        n_share = div_rsp.quot;
                        n_rem   = div_rsp.rem;
                        n_pos   = '0;
                        n_neg   = 1'b0;
                    end else begin
                        n_bud = r_bud - (r_gap * r_cnt);
                    end
                end
            end
            S_RAISE: begin
                if (r_dt_vld && hit) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_next;
                end
                if (row_end) begin
                    n_cur  = r_next;
                    n_iter = iter_inc;
                end
            end
            S_NDIV1: begin
                if (div_rsp.done) begin
                    // Limit the reduction to what the minimum rows hold.
                    n_red    = (r_cur <= div_rsp.quot) ? (r_cur * r_cnt) : mag;
                    n_div_go = 1'b1;
                end
            end
            S_NDIV2: begin
                if (div_rsp.done) begin
                    n_share = div_rsp.quot;
                    n_rem   = div_rsp.rem;
                    n_pos   = '0;
                    n_neg   = 1'b1;
                end
            end
            S_SPREAD: begin
                if (r_dt_vld && hit) begin
                    ram_we    = 1'b1;
                    ram_wdata = spread_v;
                    n_pos     = r_pos + CNT_W'(1);
                end
            end
            S_MIN: begin
                if (r_dt_vld) begin
                    n_acc_min = min_new;
                    n_acc_cnt = cnt_new;
                end
                if (row_end) begin
                    n_cur = min_new;
                end
            end
            S_OUT: begin
                if (r_dt_vld) begin
                    n_o_strobe = 1'b1;
                    n_o_index  = IDX_W'(r_dt_ptr);
                    n_o_value  = rd_data;
                    n_o_min    = r_cur;
                    n_o_last   = row_end;
                end
            end
            default: n_o_strobe = 1'b0;
        endcase
    end

    always_comb begin
        div_req.go       = r_div_go;
        div_req.divisor  = r_cnt;
        unique case (r_state)
            S_NDIV1: div_req.dividend = mag;
            S_NDIV2: div_req.dividend = r_red;
            default: div_req.dividend = r_bud;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_ptr   <= '0;
            r_dt_vld   <= 1'b0;
            r_div_go   <= 1'b0;
            r_o_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_ptr   <= n_rd_ptr;
            r_dt_vld   <= n_dt_vld;
            r_div_go   <= n_div_go;
            r_o_strobe <= n_o_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_dt_ptr  <= n_dt_ptr;
        r_iter    <= n_iter;
        r_bud     <= n_bud;
        r_cur     <= n_cur;
        r_next    <= n_next;
        r_gap     <= n_gap;
        r_red     <= n_red;
        r_share   <= n_share;
        r_rem     <= n_rem;
        r_pos     <= n_pos;
        r_neg     <= n_neg;
        r_cnt     <= n_cnt;
        r_acc_min <= n_acc_min;
        r_acc_cnt <= n_acc_cnt;
        r_acc_nxt <= n_acc_nxt;
        r_o_index <= n_o_index;
        r_o_value <= n_o_value;
        r_o_min   <= n_o_min;
        r_o_last  <= n_o_last;
    end

    lfla_ram #(
        .WIDTH(ROW_W),
        .DEPTH(MAX_ROWS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(AW'(r_rd_ptr)),
        .o_rdata(rd_data)
    );

    lfla_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign o_strobe      = r_o_strobe;
    assign o_out_index   = r_o_index;
    assign o_out_value   = r_o_value;
    assign o_new_minimum = r_o_min;
    assign o_last        = r_o_last;

    // The final beat of a route appears only once the sequencer is back in idle.
    `LFLA_CHECK(a_last_idle, i_clk, i_rst_n, (o_strobe && o_last) |-> !busy, "last beat while busy")
    // Beats of one route follow each other without gaps.
    `LFLA_CHECK(a_burst, i_clk, i_rst_n, (o_strobe && !o_last) |=> o_strobe, "gap inside a route")
    // Divisions are by the count of minimum rows, which is never zero.
    `LFLA_NEVER(a_div_zero, i_clk, i_rst_n, div_req.go && (div_req.divisor == '0), "zero divisor")

endmodule

`default_nettype wire

@@ rtl/lfla_ram.sv @@
`default_nettype none

module lfla_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/lfla_div.sv @@
`default_nettype none
`include "assert_macros.svh"

module lfla_div import lfla_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp  o_rsp
);

    localparam int SW = $clog2(ROW_W);

    logic             r_busy;
    logic             r_done;
    logic [SW-1:0]    r_step;
    logic [ROW_W-1:0] r_quo;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_dvs;

    logic [CNT_W:0]   rem_sh;
    logic             ge;
    logic [CNT_W:0]   rem_nx;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        rem_sh = {r_rem, r_quo[ROW_W-1]};
        ge     = (rem_sh >= {1'b0, r_dvs});
        rem_nx = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + SW'(1);
                if (r_step == SW'(ROW_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ROW_W-2:0], ge};
            r_rem <= rem_nx[CNT_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

    `LFLA_CHECK(a_go_when_idle, i_clk, i_rst_n, i_req.go |-> !r_busy, "divide started while busy")
    `LFLA_CHECK(a_done_pulse, i_clk, i_rst_n, r_done |=> !r_done, "done held for two cycles")

endmodule

`default_nettype wire
